### rtl/core/rhc_pkg.sv
// Shared constants, types and helpers for the row activation counter table.
`default_nettype none
package rhc_pkg;
  localparam int RANKS            = 2;
  localparam int BANK_GROUPS      = 4;
  localparam int BANKS_PER_GROUP  = 4;
  localparam int ENTRIES_PER_BANK = 32;
  localparam int ROW_BITS         = 17;
  localparam int COUNT_BITS       = 16;

  localparam int NUM_BANKS   = RANKS * BANK_GROUPS * BANKS_PER_GROUP;
  localparam int NUM_ENTRIES = NUM_BANKS * ENTRIES_PER_BANK;
  localparam int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int ENT_W       = (ENTRIES_PER_BANK > 1) ? $clog2(ENTRIES_PER_BANK) : 1;
  localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LIFE_W      = 16;
  localparam int CFG_W       = 16;
  localparam int ROW_PORT_W  = 17;

  localparam logic [1:0] CMD_ACT = 2'd1;
  localparam logic [1:0] CMD_REF = 2'd2;

  localparam logic REG_HAMMER = 1'b0;
  localparam logic REG_PRUNE  = 1'b1;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    logic [COUNT_BITS-1:0] count;
    logic [LIFE_W-1:0]     life;
  } entry_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic                  rank;
    logic [1:0]            bgroup;
    logic [1:0]            bank;
    logic [ROW_PORT_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic                  vrr_issue;
    logic                  vrr_rank;
    logic [1:0]            vrr_bgroup;
    logic [1:0]            vrr_bank;
    logic [ROW_PORT_W-1:0] vrr_row;
    logic                  table_full;
  } result_t;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [BANK_W-1:0] b,
                                                   input logic [ENT_W-1:0] i);
    return ADDR_W'(int'(b) * ENTRIES_PER_BANK + int'(i));
  endfunction
endpackage
`default_nettype wire

### rtl/core/rhc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module rhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/rhc_ctrl.sv
// Sequencer for activate lookup/insert and refresh prune/age over the table RAMs.
`default_nettype none
module rhc_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rhc_pkg::item_t            item,
  input  wire logic [rhc_pkg::CFG_W-1:0] hammer_threshold,
  input  wire logic [rhc_pkg::CFG_W-1:0] prune_threshold,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output rhc_pkg::result_t               res
);
  import rhc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_AVLD, S_ASCAN, S_ADEC, S_RVLD, S_RMUL, S_RCMP, S_FIN
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LIFE_W-1:0]     LIFE_MAX  = '1;
  localparam logic [ENT_W-1:0]      IDX_LAST  = ENT_W'(ENTRIES_PER_BANK - 1);
  localparam logic [BANK_W-1:0]     BANK_LAST = BANK_W'(NUM_BANKS - 1);

  state_t                  state;
  logic [BANK_W-1:0]       clr_ctr;
  logic [BANK_W-1:0]       bank_q;
  logic [ENT_W-1:0]        idx;
  logic [ENTRIES_PER_BANK-1:0] vvec;
  logic [ROW_BITS-1:0]     row_q;
  logic                    rank_q;
  logic [1:0]              bg_q;
  logic [1:0]              bk_q;
  logic                    found;
  logic                    have_free;
  logic [ENT_W-1:0]        hit_idx;
  logic [ENT_W-1:0]        free_idx;
  entry_t                  hit_e;
  entry_t                  ent_q;
  logic                    vbit_q;
  logic [31:0]             rhs_q;
  result_t                 res_q;

  logic                    v_we;
  logic [BANK_W-1:0]       v_waddr;
  logic [ENTRIES_PER_BANK-1:0] v_wdata;
  logic [BANK_W-1:0]       v_raddr;
  logic [ENTRIES_PER_BANK-1:0] v_rdata;
  logic                    e_we;
  logic [ADDR_W-1:0]       e_waddr;
  entry_t                  e_wdata;
  logic [ADDR_W-1:0]       e_raddr;
  entry_t                  e_rdata;

  logic                    accept;
  logic                    in_range;
  logic [BANK_W-1:0]       in_bank;
  logic [ROW_BITS-1:0]     in_row;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    issue;
  logic [ENTRIES_PER_BANK-1:0] vvec_a;
  logic                    prune;
  logic [ENTRIES_PER_BANK-1:0] vvec_r;

  rhc_ram #(.WIDTH(ENTRIES_PER_BANK), .DEPTH(NUM_BANKS), .AW(BANK_W)) u_valid_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  rhc_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_ENTRIES), .AW(ADDR_W)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_FIN);
  assign res       = res_q;

  always_comb begin
    in_range = (32'(item.rank) < RANKS) && (32'(item.bgroup) < BANK_GROUPS) &&
               (32'(item.bank) < BANKS_PER_GROUP);
    in_bank  = BANK_W'((int'(item.rank) * BANK_GROUPS + int'(item.bgroup)) *
                       BANKS_PER_GROUP + int'(item.bank));
    in_row   = ROW_BITS'(item.row);

    cnt_inc = (hit_e.count == COUNT_MAX) ? hit_e.count : hit_e.count + COUNT_BITS'(1);
    issue   = found && (32'(cnt_inc) >= 32'(hammer_threshold));
    vvec_a  = vvec;
    if (!found && have_free) begin
      vvec_a[free_idx] = 1'b1;
    end
    if (issue) begin
      vvec_a[hit_idx] = 1'b0;
    end

    prune  = 48'({ent_q.count, 8'h00}) < 48'(rhs_q);
    vvec_r = vvec;
    if (vbit_q && prune) begin
      vvec_r[idx] = 1'b0;
    end

    v_we    = 1'b0;
    v_waddr = bank_q;
    v_wdata = vvec_a;
    v_raddr = bank_q;
    e_we    = 1'b0;
    e_waddr = entry_addr(bank_q, hit_idx);
    e_wdata = hit_e;
    e_raddr = entry_addr(bank_q, idx + ENT_W'(1));

    unique case (state)
      S_CLR: begin
        v_we    = 1'b1;
        v_waddr = clr_ctr;
        v_wdata = '0;
      end
      S_IDLE: begin
        v_raddr = (item.cmd == CMD_REF) ? '0 : in_bank;
      end
      S_AVLD, S_RVLD: begin
        e_raddr = entry_addr(bank_q, '0);
      end
      S_ADEC: begin
        v_we = 1'b1;
        if (!found && have_free) begin
          e_we    = 1'b1;
          e_waddr = entry_addr(bank_q, free_idx);
          e_wdata = '{row: row_q, count: COUNT_BITS'(1), life: '0};
        end else if (found && !issue) begin
          e_we    = 1'b1;
          e_wdata = '{row: hit_e.row, count: cnt_inc, life: hit_e.life};
        end
      end
      S_RCMP: begin
        e_waddr = entry_addr(bank_q, idx);
        e_wdata = '{row: ent_q.row, count: ent_q.count, life: ent_q.life + LIFE_W'(1)};
        e_we    = vbit_q && !prune && (ent_q.life != LIFE_MAX);
        v_wdata = vvec_r;
        if (idx == IDX_LAST) begin
          v_we    = 1'b1;
          v_raddr = bank_q + BANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_ctr <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_ctr <= clr_ctr + BANK_W'(1);
          if (clr_ctr == BANK_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            row_q  <= in_row;
            rank_q <= item.rank;
            bg_q   <= item.bgroup;
            bk_q   <= item.bank;
            res_q  <= '0;
            if (item.cmd == CMD_REF) begin
              bank_q <= '0;
              state  <= S_RVLD;
            end else if (item.cmd == CMD_ACT && in_range) begin
              bank_q <= in_bank;
              state  <= S_AVLD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_AVLD: begin
          vvec      <= v_rdata;
          idx       <= '0;
          found     <= 1'b0;
          have_free <= 1'b0;
          state     <= S_ASCAN;
        end
        S_ASCAN: begin
          if (vvec[idx]) begin
            if (!found && e_rdata.row == row_q) begin
              found   <= 1'b1;
              hit_idx <= idx;
              hit_e   <= e_rdata;
            end
          end else if (!have_free) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          idx <= idx + ENT_W'(1);
          if (idx == IDX_LAST) begin
            state <= S_ADEC;
          end
        end
        S_ADEC: begin
          res_q.vrr_issue  <= issue;
          res_q.vrr_rank   <= issue ? rank_q : 1'b0;
          res_q.vrr_bgroup <= issue ? bg_q : 2'd0;
          res_q.vrr_bank   <= issue ? bk_q : 2'd0;
          res_q.vrr_row    <= issue ? ROW_PORT_W'(row_q) : '0;
          res_q.table_full <= !found && !have_free;
          state            <= S_FIN;
        end
        S_RVLD: begin
          vvec  <= v_rdata;
          idx   <= '0;
          state <= S_RMUL;
        end
        S_RMUL: begin
          ent_q  <= e_rdata;
          vbit_q <= vvec[idx];
          rhs_q  <= 32'(e_rdata.life) * 32'(prune_threshold);
          state  <= S_RCMP;
        end
        S_RCMP: begin
          vvec <= vvec_r;
          idx  <= idx + ENT_W'(1);
          if (idx == IDX_LAST) begin
            bank_q <= bank_q + BANK_W'(1);
            state  <= (bank_q == BANK_LAST) ? S_FIN : S_RVLD;
          end else begin
            state <= S_RMUL;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/rowhammer_act_counter_table_core.sv
// Top level: configuration registers, sequencer and result output register.
//
// Usage: commands arrive on the in_valid/in_ready channel (cmd, rank,
// bgroup, bank, row); every transaction yields exactly one result on the
// out_valid/out_ready channel. Thresholds are written through cfg_we,
// cfg_index and cfg_data; the user should do so only while the block is idle, which the block does not enforce.
// Activate: the bank is scanned one entry per cycle through the entry RAM
// read port, then the table is updated. A refresh walks every entry of every
// bank, reading the valid vector of each bank first. Other commands go
// straight to the result.
// One command is processed at a time; the next one is taken while a finished
// result still sits in the output register.
// Reset: thresholds return to defaults and a clearing pass over all NUM_BANKS
// words (32) wipes the valid RAM; in_ready stays low until it completes.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its next result until that register frees up.
`default_nettype none
module rowhammer_act_counter_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic        rank,
  input  wire logic [1:0]  bgroup,
  input  wire logic [1:0]  bank,
  input  wire logic [16:0] row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             vrr_issue,
  output logic             vrr_rank,
  output logic [1:0]       vrr_bgroup,
  output logic [1:0]       vrr_bank,
  output logic [16:0]      vrr_row,
  output logic             table_full
);
  import rhc_pkg::*;

  logic [CFG_W-1:0] hammer_threshold;
  logic [CFG_W-1:0] prune_threshold;
  item_t            item;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_q;

  assign item = '{cmd: cmd, rank: rank, bgroup: bgroup, bank: bank, row: row};

  always_ff @(posedge clk) begin
    if (rst) begin
      hammer_threshold <= CFG_W'(32768);
      prune_threshold  <= CFG_W'(1024);
    end else if (cfg_we) begin
      if (cfg_index == REG_HAMMER) begin
        hammer_threshold <= cfg_data;
      end else if (cfg_index == REG_PRUNE) begin
        prune_threshold <= cfg_data;
      end
    end
  end

  rhc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .item(item),
    .hammer_threshold(hammer_threshold), .prune_threshold(prune_threshold),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign vrr_issue  = out_q.vrr_issue;
  assign vrr_rank   = out_q.vrr_rank;
  assign vrr_bgroup = out_q.vrr_bgroup;
  assign vrr_bank   = out_q.vrr_bank;
  assign vrr_row    = out_q.vrr_row;
  assign table_full = out_q.table_full;
endmodule
`default_nettype wire
